### rtl/core/vpl_pkg.sv
// Shared types and fixed constants for the filtered PI velocity loop.
package vpl_pkg;

   localparam int DATA_W     = 16;            // item fields and config registers
   localparam int ERR_W      = DATA_W + 1;    // measured minus target
   localparam int FILT_W     = 26;            // filtered error state
   localparam int COEF_OLD   = 205;           // 0.8 in Q8
   localparam int COEF_NEW   = 51;            // 0.2 in Q8
   localparam int COEF_SHIFT = 8;
   localparam int GAIN_FRAC  = 8;             // Q8.8 gains
   localparam int MUL_W      = 16;            // serial multiplier operand width
   localparam int CNT_W      = $clog2(MUL_W);
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // register index; byte address is index * 4
   typedef enum logic [1:0] {
      IDX_PROP_GAIN,
      IDX_INTEG_GAIN,
      IDX_TARGET_VEL,
      IDX_SPARE
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prop_gain;
      logic signed [DATA_W-1:0] integ_gain;
      logic signed [DATA_W-1:0] target_velocity;
   } cfg_type;

   typedef struct packed {
      logic load;    // take new operands, start a 16-step pass
      logic clear;   // zero the accumulator on load
   } mac_ctrl_type;

endpackage

### rtl/core/vpl_csr.sv
// APB-style register file for gains and target velocity.
module vpl_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vpl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [vpl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [vpl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output vpl_pkg::cfg_type                  cfg
);
   import vpl_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type reg_idx;
   logic          wr_en;

   assign reg_idx    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            IDX_PROP_GAIN:  cfg_in.prop_gain       = csr_pwdata[DATA_W-1:0];
            IDX_INTEG_GAIN: cfg_in.integ_gain      = csr_pwdata[DATA_W-1:0];
            IDX_TARGET_VEL: cfg_in.target_velocity = csr_pwdata[DATA_W-1:0];
            default:        cfg_in = cfg_ff;   // unmapped: ignored
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         IDX_PROP_GAIN:  csr_prdata = CSR_DATA_W'(cfg_ff.prop_gain);
         IDX_INTEG_GAIN: csr_prdata = CSR_DATA_W'(cfg_ff.integ_gain);
         IDX_TARGET_VEL: csr_prdata = CSR_DATA_W'(cfg_ff.target_velocity);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/vpl_serial_mac.sv
// Bit-serial shift-add multiply-accumulate, one multiplier bit per cycle.
module vpl_serial_mac #(
   parameter int ACC_W = 50
) (
   input  logic                                clock,
   input  logic                                reset,
   input  vpl_pkg::mac_ctrl_type               ctrl,
   input  logic signed [ACC_W-1:0]             mcand,
   input  logic signed [vpl_pkg::MUL_W-1:0]    mplier,
   output logic signed [ACC_W-1:0]             acc,
   output logic                                done
);
   import vpl_pkg::*;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] mcand_ff, mcand_in;
   logic        [MUL_W-1:0] mplier_ff, mplier_in;
   logic        [CNT_W-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    last;
   logic signed [ACC_W-1:0] addend;

   assign last = (cnt_ff == CNT_W'(MUL_W - 1));

   // Multiplier is two's complement: its top bit weighs negative.
   always_comb begin
      if (!mplier_ff[0]) begin
         addend = '0;
      end else if (last) begin
         addend = -mcand_ff;
      end else begin
         addend = mcand_ff;
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      if (ctrl.load) begin
         acc_in    = ctrl.clear ? '0 : acc_ff;
         mcand_in  = mcand;
         mplier_in = mplier;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = acc_ff + addend;
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + CNT_W'(1);
         busy_in   = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign acc  = acc_ff;
   assign done = busy_ff && last;

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> !busy_ff)
      else $error("serial mac reloaded mid-pass");

endmodule

### rtl/core/velocity_pi_loop_filtered.sv
// Top level: filtered PI velocity loop with clamped integral, bit-serial datapath.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   req     | in        | req_valid/req_stall  | req_measured_velocity, req_command_shift
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_drive_value
//   csr     | in/out    | psel/penable/pready  | paddr, pwdata, prdata (APB-style)
//
// One item at a time: a new item is taken only once the last result is registered.
// Each item takes four 16-step passes of the single shift-add MAC, each begun by a
// load state, plus filter store, integral update and output stages. Synchronous
// active-high reset clears the state machine, filter and integral state, the valid
// flag and config registers, but not the data registers. A stalled result holds in
// the output register; the block idles in its output stage until the slot frees.
module velocity_pi_loop_filtered #(
   parameter int FRAC_BITS      = 8,
   parameter int INTEGRAL_LIMIT = 10000
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // item in
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [vpl_pkg::DATA_W-1:0]    req_measured_velocity,
   input  logic signed [vpl_pkg::DATA_W-1:0]    req_command_shift,
   // item out
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [vpl_pkg::DATA_W-1:0]    rsp_drive_value,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [vpl_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [vpl_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [vpl_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import vpl_pkg::*;

   // Integral limit in Q(FRAC_BITS) and the widths that follow from it.
   localparam longint LIMIT_Q = longint'(INTEGRAL_LIMIT) << FRAC_BITS;
   localparam int INTEG_W = $clog2(LIMIT_Q + 1) + 1;
   localparam int SHIFT_W = DATA_W + FRAC_BITS;
   localparam int SUM_A   = (INTEG_W > FILT_W) ? INTEG_W : FILT_W;
   localparam int SUM_W   = ((SUM_A > SHIFT_W) ? SUM_A : SHIFT_W) + 2;

   // Accumulator: widest product, with the multiplicand shifted up to MUL_W-1.
   localparam int PROD_A = (FILT_W > INTEG_W) ? FILT_W : INTEG_W;
   localparam int PROD_B = ERR_W + FRAC_BITS;
   localparam int ACC_W  = ((PROD_A > PROD_B) ? PROD_A : PROD_B) + MUL_W + 2;

   localparam int OUT_SHIFT = GAIN_FRAC + FRAC_BITS;

   localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(LIMIT_Q);
   localparam logic signed [SUM_W-1:0] LIM_NEG = -LIM_POS;

   localparam logic signed [ACC_W-1:0] F_MAX =
      {{(ACC_W-FILT_W+1){1'b0}}, {(FILT_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] F_MIN =
      {{(ACC_W-FILT_W+1){1'b1}}, {(FILT_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] RND_BIAS =
      ACC_W'((longint'(1) << OUT_SHIFT) - 1);
   localparam logic signed [ACC_W-1:0] D_MAX = ACC_W'(2**(DATA_W-1) - 1);
   localparam logic signed [ACC_W-1:0] D_MIN = ACC_W'(-(2**(DATA_W-1)));

   typedef enum logic [3:0] {
      S_IDLE,
      S_F_OLD, S_F_OLD_W,     // acc  = 205 * filtered
      S_F_NEW, S_F_NEW_W,     // acc += 51 * (err << FRAC_BITS)
      S_F_STORE,              // floor >> 8, saturate to 26 bits
      S_INTEG,                // integral update and clamp
      S_P_MUL, S_P_MUL_W,     // acc  = Kp * filtered
      S_I_MUL, S_I_MUL_W,     // acc += Ki * integral
      S_OUTPUT                // truncate toward zero, saturate, register
   } state_type;

   state_type                 state_ff, state_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DATA_W-1:0]  shift_ff, shift_in;
   logic signed [FILT_W-1:0]  filt_ff, filt_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_drive_ff, rsp_drive_in;

   cfg_type                   cfg;
   mac_ctrl_type              mac_ctrl;
   logic signed [ACC_W-1:0]   mac_mcand;
   logic signed [MUL_W-1:0]   mac_mplier;
   logic signed [ACC_W-1:0]   mac_acc;
   logic                      mac_done;

   logic signed [ACC_W-1:0]   filt_shr;
   logic signed [FILT_W-1:0]  filt_sat;
   logic signed [SUM_W-1:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_sat;
   logic signed [ACC_W-1:0]   out_bias;
   logic signed [ACC_W-1:0]   out_biased;
   logic signed [ACC_W-1:0]   out_quot;
   logic signed [DATA_W-1:0]  out_sat;
   logic                      out_free;

   vpl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vpl_serial_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .mcand  (mac_mcand),
      .mplier (mac_mplier),
      .acc    (mac_acc),
      .done   (mac_done)
   );

   // MAC operand select; a load state starts one 16-step pass.
   always_comb begin
      mac_ctrl   = '0;
      mac_mcand  = ACC_W'(filt_ff);
      mac_mplier = MUL_W'(COEF_OLD);
      unique case (state_ff)
         S_F_OLD: begin
            mac_ctrl.load  = 1'b1;
            mac_ctrl.clear = 1'b1;
         end
         S_F_NEW: begin
            mac_ctrl.load = 1'b1;
            mac_mcand     = ACC_W'(err_ff) <<< FRAC_BITS;
            mac_mplier    = MUL_W'(COEF_NEW);
         end
         S_P_MUL: begin
            mac_ctrl.load  = 1'b1;
            mac_ctrl.clear = 1'b1;
            mac_mplier     = cfg.prop_gain;
         end
         S_I_MUL: begin
            mac_ctrl.load = 1'b1;
            mac_mcand     = ACC_W'(integ_ff);
            mac_mplier    = cfg.integ_gain;
         end
         default: begin
            mac_ctrl = '0;
         end
      endcase
   end

   // Filter: arithmetic shift is the floor division by 256.
   always_comb begin
      filt_shr = mac_acc >>> COEF_SHIFT;
      if (filt_shr > F_MAX) begin
         filt_sat = F_MAX[FILT_W-1:0];
      end else if (filt_shr < F_MIN) begin
         filt_sat = F_MIN[FILT_W-1:0];
      end else begin
         filt_sat = filt_shr[FILT_W-1:0];
      end
   end

   // Integral: full precision, then clamp to +-limit.
   always_comb begin
      integ_sum = SUM_W'(integ_ff) + SUM_W'(filt_ff) - (SUM_W'(shift_ff) <<< FRAC_BITS);
      if (integ_sum > LIM_POS) begin
         integ_sat = LIM_POS[INTEG_W-1:0];
      end else if (integ_sum < LIM_NEG) begin
         integ_sat = LIM_NEG[INTEG_W-1:0];
      end else begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end
   end

   // Output: bias negatives so the arithmetic shift truncates toward zero.
   always_comb begin
      out_bias   = mac_acc[ACC_W-1] ? RND_BIAS : ACC_W'(0);
      out_biased = mac_acc + out_bias;
      out_quot   = out_biased >>> OUT_SHIFT;
      if (out_quot > D_MAX) begin
         out_sat = D_MAX[DATA_W-1:0];
      end else if (out_quot < D_MIN) begin
         out_sat = D_MIN[DATA_W-1:0];
      end else begin
         out_sat = out_quot[DATA_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      shift_in     = shift_ff;
      filt_in      = filt_ff;
      integ_in     = integ_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_drive_in = rsp_drive_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               err_in   = ERR_W'(req_measured_velocity) - ERR_W'(cfg.target_velocity);
               shift_in = req_command_shift;
               state_in = S_F_OLD;
            end
         end
         S_F_OLD:   state_in = S_F_OLD_W;
         S_F_OLD_W: if (mac_done) state_in = S_F_NEW;
         S_F_NEW:   state_in = S_F_NEW_W;
         S_F_NEW_W: if (mac_done) state_in = S_F_STORE;
         S_F_STORE: begin
            filt_in  = filt_sat;
            state_in = S_INTEG;
         end
         S_INTEG: begin
            integ_in = integ_sat;
            state_in = S_P_MUL;
         end
         S_P_MUL:   state_in = S_P_MUL_W;
         S_P_MUL_W: if (mac_done) state_in = S_I_MUL;
         S_I_MUL:   state_in = S_I_MUL_W;
         S_I_MUL_W: if (mac_done) state_in = S_OUTPUT;
         S_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = out_sat;
               state_in     = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filt_ff      <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filt_ff      <= filt_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff       <= err_in;
      shift_ff     <= shift_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = rsp_drive_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is in flight");

   a_integ_in_limit: assert property (@(posedge clock) disable iff (reset)
      (SUM_W'(integ_ff) <= LIM_POS) && (SUM_W'(integ_ff) >= LIM_NEG))
      else $error("integral outside clamp range");

   a_rsp_from_output: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUTPUT))
      else $error("result raised outside output stage");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUTPUT && rsp_valid_ff && rsp_stall) |=> (state_ff == S_OUTPUT))
      else $error("result overwritten while stalled");

endmodule
